// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the keepalive monitor RTL.
// No dependencies; included by the files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that holds at every clock edge outside reset
`define HKM_ASSERT(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication
`define HKM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define HKM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hkm_pkg.sv =====
// Shared types and constants for the heartbeat keepalive monitor.
// No dependencies; used by every RTL file of the block but assert_macros.svh.
package hkm_pkg;

  localparam int HKM_QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_W     = 4;
  localparam int CFG_DATA_W      = 16;
  localparam int LIMIT_W         = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_LOSS_THRESH = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_CMD_CODE    = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LEN     = CFG_INDEX_W'(3);

  localparam logic [7:0]  DEFAULT_LOSS_THRESH = 8'd3;
  localparam logic [15:0] DEFAULT_MIN_LEN     = 16'd8;
  localparam logic [7:0]  QUERY_WINDOW        = 8'h80;

  localparam logic        REQ_TICK   = 1'b0;

  typedef enum logic [1:0] {
    OP_TICK_OFF = 2'd0,
    OP_TICK     = 2'd1,
    OP_BAD      = 2'd2,
    OP_FRAME    = 2'd3
  } op_t;

  // Classified item handed from front to back
  typedef struct packed {
    op_t         op;
    logic        from_manager;
    logic [31:0] now_sec;
    logic [7:0]  rx_msg_id;
  } item_t;

  // Configuration the back part needs
  typedef struct packed {
    logic [15:0]        interval_sec;
    logic [7:0]         loss_thresh;
    logic [LIMIT_W-1:0] loss_limit;
  } back_cfg_t;

endpackage

// ===== hw/rtl/hkm_if.sv =====
// Handshake channel interfaces of the keepalive monitor: request, result, config.
// Depends on hkm_pkg for the configuration port widths.
interface hkm_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] now_sec;
  logic [15:0] frame_len;
  logic [15:0] frame_cmd;
  logic        from_manager;
  logic [7:0]  rx_msg_id;

  modport source (output valid, req_type, now_sec, frame_len, frame_cmd, from_manager,
                  rx_msg_id, input ready);
  modport sink (input valid, req_type, now_sec, frame_len, frame_cmd, from_manager,
                rx_msg_id, output ready);
endinterface

interface hkm_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        send_heartbeat;
  logic        send_reply;
  logic [7:0]  out_msg_id;
  logic        lost_event;
  logic        link_lost;
  logic [15:0] loss_run;
  logic        awaiting_reply;
  logic [31:0] sent_total;
  logic [31:0] received_total;

  modport source (output valid, status, send_heartbeat, send_reply, out_msg_id, lost_event,
                  link_lost, loss_run, awaiting_reply, sent_total, received_total,
                  input ready);
  modport sink (input valid, status, send_heartbeat, send_reply, out_msg_id, lost_event,
                link_lost, loss_run, awaiting_reply, sent_total, received_total,
                output ready);
endinterface

interface hkm_cfg_if import hkm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/hkm_front.sv =====
// Front part: configuration registers and classification of incoming items.
// Depends on hkm_pkg and hkm_if; feeds hkm_queue.
module hkm_front import hkm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  hkm_req_if.sink    req,
  hkm_cfg_if.sink    cfg,
  input  logic       queue_ready,
  output logic       push,
  output item_t      push_item,
  output back_cfg_t  back_cfg
);

  logic [15:0]        interval_sec;
  logic [7:0]         loss_thresh;
  logic [15:0]        heartbeat_cmd_code;
  logic [15:0]        min_header_len;
  logic [LIMIT_W-1:0] loss_limit;
  logic [7:0]         loss_thresh_eff;
  logic               frame_ok;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_sec       <= '0;
      loss_thresh        <= DEFAULT_LOSS_THRESH;
      heartbeat_cmd_code <= '0;
      min_header_len     <= DEFAULT_MIN_LEN;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_INTERVAL:    interval_sec       <= cfg.data;
        CFG_LOSS_THRESH: loss_thresh        <= cfg.data[7:0];
        CFG_CMD_CODE:    heartbeat_cmd_code <= cfg.data;
        CFG_MIN_LEN:     min_header_len     <= cfg.data;
        default:         ;
      endcase
    end
  end

  assign loss_thresh_eff = (loss_thresh == '0) ? DEFAULT_LOSS_THRESH : loss_thresh;

  // Loss timeout is registered next cycle; user moves config only while idle, unchecked
  always_ff @(posedge clk) begin
    loss_limit <= LIMIT_W'(interval_sec * loss_thresh_eff);
  end

  assign back_cfg.interval_sec = interval_sec;
  assign back_cfg.loss_thresh  = loss_thresh_eff;
  assign back_cfg.loss_limit   = loss_limit;

  assign frame_ok = (req.frame_len >= min_header_len) && (req.frame_cmd == heartbeat_cmd_code);

  always_comb begin
    push_item.from_manager = req.from_manager;
    push_item.now_sec      = req.now_sec;
    push_item.rx_msg_id    = req.rx_msg_id;
    if (req.req_type == REQ_TICK) begin
      push_item.op = (interval_sec == '0) ? OP_TICK_OFF : OP_TICK;
    end else begin
      push_item.op = frame_ok ? OP_FRAME : OP_BAD;
    end
  end

  assign req.ready = queue_ready;
  assign push      = req.valid && queue_ready;

endmodule

// ===== hw/rtl/hkm_queue.sv =====
// Short item queue between the front and back parts of the keepalive monitor.
// Depends on hkm_pkg for the item type.
`include "assert_macros.svh"
module hkm_queue import hkm_pkg::*; #(
  parameter int DEPTH = HKM_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  push_ready,
  input  logic  pop,
  output logic  pop_valid,
  output item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t           slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `HKM_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH), "queue count beyond depth")
  `HKM_ASSERT_IMP(a_no_overflow, clk, rst, push, push_ready, "push into full queue")
  `HKM_ASSERT_IMP(a_no_underflow, clk, rst, pop, pop_valid, "pop from empty queue")

endmodule

// ===== hw/rtl/hkm_back.sv =====
// Back part: keepalive state, timeout and id logic, and the result register.
// Depends on hkm_pkg and hkm_if; drains hkm_queue.
`include "assert_macros.svh"
module hkm_back import hkm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  back_cfg_t  back_cfg,
  input  logic       pop_valid,
  input  item_t      pop_item,
  output logic       pop,
  hkm_rsp_if.source  rsp
);

  // id_counter doubles as the expected id: every heartbeat sets both to the same value
  logic        sent_once;
  logic [31:0] last_send_time;
  logic        pending_flag;
  logic [31:0] pending_start_time;
  logic [7:0]  id_counter;
  logic [15:0] loss_counter;
  logic [31:0] send_counter;
  logic [31:0] receive_counter;

  logic        sent_once_next;
  logic [31:0] last_send_time_next;
  logic        pending_flag_next;
  logic [31:0] pending_start_time_next;
  logic [7:0]  id_counter_next;
  logic [15:0] loss_counter_next;
  logic [31:0] send_counter_next;
  logic [31:0] receive_counter_next;

  logic        status_next;
  logic        send_hb_next;
  logic        send_rep_next;
  logic [7:0]  oid_next;
  logic        lost_next;
  logic        link_next;

  logic [31:0] since_send;
  logic [31:0] since_pend;
  logic [7:0]  id_diff;
  logic        due;
  logic        timed_out;
  logic        pend_mid;

  assign pop = pop_valid && (!rsp.valid || rsp.ready);

  assign since_send = pop_item.now_sec - last_send_time;
  assign since_pend = pop_item.now_sec - pending_start_time;
  assign id_diff    = pop_item.rx_msg_id - id_counter;
  assign due        = !sent_once || (since_send >= {16'd0, back_cfg.interval_sec});
  assign timed_out  = pending_flag && (since_pend >= {8'd0, back_cfg.loss_limit});

  always_comb begin
    sent_once_next          = sent_once;
    last_send_time_next     = last_send_time;
    pending_flag_next       = pending_flag;
    pending_start_time_next = pending_start_time;
    id_counter_next         = id_counter;
    loss_counter_next       = loss_counter;
    send_counter_next       = send_counter;
    receive_counter_next    = receive_counter;
    status_next             = 1'b0;
    send_hb_next            = 1'b0;
    send_rep_next           = 1'b0;
    oid_next                = '0;
    lost_next               = 1'b0;
    link_next               = 1'b0;
    pend_mid                = pending_flag;

    unique case (pop_item.op)
      OP_TICK_OFF: ;
      OP_TICK: begin
        if (timed_out) begin
          lost_next = 1'b1;
          pend_mid  = 1'b0;
          if (loss_counter != '1) begin
            loss_counter_next = loss_counter + 1'b1;
          end
          link_next = (loss_counter_next >= {8'd0, back_cfg.loss_thresh});
        end
        pending_flag_next = pend_mid;
        if (due) begin
          if (!pend_mid) begin
            pending_start_time_next = pop_item.now_sec;
          end
          id_counter_next     = id_counter + 1'b1;
          last_send_time_next = pop_item.now_sec;
          sent_once_next      = 1'b1;
          pending_flag_next   = 1'b1;
          if (send_counter != '1) begin
            send_counter_next = send_counter + 1'b1;
          end
          send_hb_next = 1'b1;
          oid_next     = id_counter_next;
        end
      end
      OP_BAD: begin
        status_next = 1'b1;
      end
      OP_FRAME: begin
        if (receive_counter != '1) begin
          receive_counter_next = receive_counter + 1'b1;
        end
        loss_counter_next = '0;
        if (pop_item.from_manager) begin
          if (pending_flag && (pop_item.rx_msg_id == id_counter)) begin
            pending_flag_next = 1'b0;
          end else if (id_diff < QUERY_WINDOW) begin
            // newer id from the manager: answer as a query
            send_rep_next = 1'b1;
            oid_next      = pop_item.rx_msg_id;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_once          <= 1'b0;
      last_send_time     <= '0;
      pending_flag       <= 1'b0;
      pending_start_time <= '0;
      id_counter         <= '0;
      loss_counter       <= '0;
      send_counter       <= '0;
      receive_counter    <= '0;
    end else if (pop) begin
      sent_once          <= sent_once_next;
      last_send_time     <= last_send_time_next;
      pending_flag       <= pending_flag_next;
      pending_start_time <= pending_start_time_next;
      id_counter         <= id_counter_next;
      loss_counter       <= loss_counter_next;
      send_counter       <= send_counter_next;
      receive_counter    <= receive_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (pop) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp.status         <= status_next;
      rsp.send_heartbeat <= send_hb_next;
      rsp.send_reply     <= send_rep_next;
      rsp.out_msg_id     <= oid_next;
      rsp.lost_event     <= lost_next;
      rsp.link_lost      <= link_next;
      rsp.loss_run       <= loss_counter_next;
      rsp.awaiting_reply <= pending_flag_next;
      rsp.sent_total     <= send_counter_next;
      rsp.received_total <= receive_counter_next;
    end
  end

  `HKM_ASSERT_IMP(a_one_order, clk, rst, rsp.valid, !(rsp.send_heartbeat && rsp.send_reply),
                  "heartbeat and reply ordered by one item")
  `HKM_ASSERT_IMP(a_hb_arms, clk, rst, rsp.valid && rsp.send_heartbeat, rsp.awaiting_reply,
                  "heartbeat sent without pending expectation")
  `HKM_ASSERT_IMP(a_link_on_loss, clk, rst, rsp.valid && rsp.link_lost, rsp.lost_event,
                  "link alarm without a loss")
  `HKM_ASSERT_NEXT(a_hb_id, clk, rst, pop && send_hb_next, rsp.out_msg_id == id_counter,
                   "heartbeat id differs from id counter")

endmodule

// ===== hw/rtl/heartbeat_keepalive_monitor.sv =====
// Heartbeat keepalive monitor, top level: front, item queue and back part.
// Depends on hkm_pkg, hkm_if, hkm_front, hkm_queue and hkm_back.
//
// Use: items arrive on req, each a timer tick (req_type 0, now_sec) or a
// received heartbeat header (req_type 1 with length, command, sender flag and
// id). Every item yields exactly one result on rsp, in order: status, the
// heartbeat or reply order with its id, loss and link alarms, and the
// counters after the item. Registers are written on cfg (index 0 interval,
// 1 loss threshold, 2 command code, 3 minimum header length) while no item is
// in flight; cfg is always ready.
// A result is valid the cycle after its item leaves the queue.
// Throughput: one item per cycle while the receiver keeps rsp.ready high.
// The back part updates its keepalive state as each item pops.
// Reset clears the keepalive state, the queue and the result valid flag and
// loads the register defaults. When the receiver stalls, the result holds and
// up to QUEUE_DEPTH further items are taken before req.ready drops.
module heartbeat_keepalive_monitor import hkm_pkg::*; #(
  parameter int QUEUE_DEPTH = HKM_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  hkm_req_if.sink    req,
  hkm_rsp_if.source  rsp,
  hkm_cfg_if.sink    cfg
);

  logic      queue_ready;
  logic      push;
  item_t     push_item;
  logic      pop;
  logic      pop_valid;
  item_t     pop_item;
  back_cfg_t back_cfg;

  hkm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .cfg         (cfg),
    .queue_ready (queue_ready),
    .push        (push),
    .push_item   (push_item),
    .back_cfg    (back_cfg)
  );

  hkm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (queue_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  hkm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .back_cfg  (back_cfg),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .rsp       (rsp)
  );

endmodule
